FILE: src/fsrs_pkg.sv
// -----------------------------------------------------------------------------
// fsrs_pkg
// Shared types and constants for the freeze-scan request scheduler: the
// request and response beat layouts, status codes and controller states.
// -----------------------------------------------------------------------------
package fsrs_pkg;

   localparam int QUEUE_DEPTH_DEF   = 64;
   localparam int POSITION_BITS_DEF = 16;
   localparam int ID_BITS           = 16;
   localparam int FIELD_BITS        = 16;

   // Action codes carried by a request beat.
   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_GET = 1'b1;

   typedef enum logic [2:0] {
      ST_ADD_ACTIVE  = 3'd0,
      ST_ADD_WAITING = 3'd1,
      ST_DROPPED     = 3'd2,
      ST_GRANTED     = 3'd3,
      ST_NONE        = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_SHIFT,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic                  action;
      logic [FIELD_BITS-1:0] request_id;
      logic [FIELD_BITS-1:0] target_position;
      logic                  device_idle;
      logic [FIELD_BITS-1:0] head_position;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [FIELD_BITS-1:0] grant_id;
      logic [FIELD_BITS-1:0] grant_position;
      logic                  moving_up;
   } rsp_type;

endpackage

FILE: src/freeze_scan_request_scheduler_core.sv
// -----------------------------------------------------------------------------
// freeze_scan_request_scheduler_core
// Two-queue freeze-scan scheduler with LOOK sweeps, queues held in two banks.
//
//   channel   ports                     direction  beat
//   request   start, busy, req          in         start & !busy
//   response  rsp_valid, rsp            out        rsp_valid (one cycle)
//
// An add is answered on the next cycle and the block is ready again at once.
// A get makes one bank read per entry for the scan, then one read and write
// per entry behind the grant to close the gap. A get that finds both queues
// empty is answered on the next cycle. Freezing swaps the bank roles.
// Reset is synchronous and empties both queues; the receiver cannot stall.
// -----------------------------------------------------------------------------
module freeze_scan_request_scheduler_core #(
   parameter int QUEUE_DEPTH   = fsrs_pkg::QUEUE_DEPTH_DEF,
   parameter int POSITION_BITS = fsrs_pkg::POSITION_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fsrs_pkg::req_type req,
   output logic              rsp_valid,
   output fsrs_pkg::rsp_type rsp
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = fsrs_pkg::ID_BITS + POSITION_BITS;

   fsrs_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                active_count_ff, active_count_in;
   logic [CW-1:0]                waiting_count_ff, waiting_count_in;
   logic                         sel_ff, sel_in;
   logic                         sweep_ff, sweep_in;
   logic [POSITION_BITS-1:0]     head_ff, head_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic                         rd_v_ff, rd_v_in;
   logic [IW-1:0]                rd_idx_ff, rd_idx_in;
   logic [IW-1:0]                sh_ff, sh_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic [IW-1:0]                wr_addr_ff, wr_addr_in;
   logic [fsrs_pkg::ID_BITS-1:0] gid_ff, gid_in;
   logic [POSITION_BITS-1:0]     gpos_ff, gpos_in;
   fsrs_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]                rd_addr, wr_addr;
   logic [EW-1:0]                wr_data, rdata0, rdata1, rdata_sel;
   logic                         we0, we1;
   logic                         pick_clear;
   logic                         pick_found;
   logic [IW-1:0]                pick_idx;
   logic [fsrs_pkg::ID_BITS-1:0] pick_id;
   logic [POSITION_BITS-1:0]     pick_pos;
   logic [31:0]                  tgt_wide, head_wide, gpos_wide;
   logic                         scan_last, pick_last, shift_last;
   logic [CW-1:0]                count_last;

   assign count_last = active_count_ff - 1'b1;
   assign scan_last  = (CW'(idx_ff) == count_last);
   assign pick_last  = (CW'(pick_idx) == count_last);
   assign shift_last = (CW'(sh_ff) == count_last);
   assign rdata_sel  = sel_ff ? rdata1 : rdata0;
   assign tgt_wide   = {16'b0, req.target_position};
   assign head_wide  = {16'b0, req.head_position};

   // Queue banks; sel_ff names the bank holding the active queue.
   fsrs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_bank0 (
      .clock(clock), .we(we0), .waddr(wr_addr), .wdata(wr_data),
      .raddr(rd_addr), .rdata(rdata0)
   );

   fsrs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_bank1 (
      .clock(clock), .we(we1), .waddr(wr_addr), .wdata(wr_data),
      .raddr(rd_addr), .rdata(rdata1)
   );

   fsrs_pick #(.QUEUE_DEPTH(QUEUE_DEPTH), .POSITION_BITS(POSITION_BITS)) u_pick (
      .clock(clock), .clear(pick_clear), .valid(rd_v_ff), .index(rd_idx_ff),
      .entry_id(rdata_sel[EW-1:POSITION_BITS]),
      .entry_pos(rdata_sel[POSITION_BITS-1:0]),
      .head(head_ff), .sweep_up(sweep_ff), .found(pick_found),
      .pick_idx(pick_idx), .pick_id(pick_id), .pick_pos(pick_pos)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsrs_pkg::S_IDLE: begin
            if (start && req.action == fsrs_pkg::ACT_GET &&
                (active_count_ff != '0 || waiting_count_ff != '0)) begin
               state_in = fsrs_pkg::S_SCAN;
            end
         end
         fsrs_pkg::S_SCAN: begin
            if (scan_last) state_in = fsrs_pkg::S_DRAIN;
         end
         fsrs_pkg::S_DRAIN:  state_in = fsrs_pkg::S_DECIDE;
         fsrs_pkg::S_DECIDE: state_in = pick_last ? fsrs_pkg::S_IDLE : fsrs_pkg::S_SHIFT;
         fsrs_pkg::S_SHIFT: begin
            if (shift_last) state_in = fsrs_pkg::S_FLUSH;
         end
         fsrs_pkg::S_FLUSH:  state_in = fsrs_pkg::S_IDLE;
         default:            state_in = fsrs_pkg::S_IDLE;
      endcase
   end

   // Datapath and bank control.
   always_comb begin
      active_count_in  = active_count_ff;
      waiting_count_in = waiting_count_ff;
      sel_in           = sel_ff;
      sweep_in         = sweep_ff;
      head_in          = head_ff;
      idx_in           = idx_ff;
      rd_v_in          = 1'b0;
      rd_idx_in        = rd_idx_ff;
      sh_in            = sh_ff;
      wr_pend_in       = 1'b0;
      wr_addr_in       = wr_addr_ff;
      gid_in           = gid_ff;
      gpos_in          = gpos_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = 1'b0;
      rd_addr          = idx_ff;
      wr_addr          = wr_addr_ff;
      wr_data          = rdata_sel;
      we0              = 1'b0;
      we1              = 1'b0;
      pick_clear       = 1'b0;
      gpos_wide        = 32'(gpos_ff);

      // A pending shift beat moves the entry read last cycle down one slot.
      if (wr_pend_ff) begin
         we0 = !sel_ff;
         we1 = sel_ff;
      end

      case (state_ff)
         fsrs_pkg::S_IDLE: begin
            if (start) begin
               rsp_in.grant_id       = '0;
               rsp_in.grant_position = '0;
               rsp_in.moving_up      = sweep_ff;
               if (req.action == fsrs_pkg::ACT_ADD) begin
                  rsp_valid_in = 1'b1;
                  wr_data = {req.request_id, tgt_wide[POSITION_BITS-1:0]};
                  if (active_count_ff == '0 && req.device_idle) begin
                     wr_addr         = '0;
                     we0             = !sel_ff;
                     we1             = sel_ff;
                     active_count_in = CW'(1);
                     rsp_in.status   = fsrs_pkg::ST_ADD_ACTIVE;
                  end else if (waiting_count_ff < CW'(QUEUE_DEPTH)) begin
                     wr_addr          = waiting_count_ff[IW-1:0];
                     we0              = sel_ff;
                     we1              = !sel_ff;
                     waiting_count_in = waiting_count_ff + 1'b1;
                     rsp_in.status    = fsrs_pkg::ST_ADD_WAITING;
                  end else begin
                     rsp_in.status = fsrs_pkg::ST_DROPPED;
                  end
               end else begin
                  // When the active queue is empty the waiting bank becomes the active one (freeze).
                  if (active_count_ff == '0) begin
                     sel_in           = !sel_ff;
                     active_count_in  = waiting_count_ff;
                     waiting_count_in = '0;
                     sweep_in         = 1'b1;
                     if (waiting_count_ff == '0) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.status    = fsrs_pkg::ST_NONE;
                        rsp_in.moving_up = 1'b1;
                     end
                  end
                  head_in    = head_wide[POSITION_BITS-1:0];
                  idx_in     = '0;
                  pick_clear = 1'b1;
               end
            end
         end
         fsrs_pkg::S_SCAN: begin
            rd_addr   = idx_ff;
            rd_v_in   = 1'b1;
            rd_idx_in = idx_ff;
            idx_in    = idx_ff + 1'b1;
         end
         fsrs_pkg::S_DRAIN: begin
         end
         fsrs_pkg::S_DECIDE: begin
            gid_in  = pick_id;
            gpos_in = pick_pos;
            if (!pick_found) sweep_in = !sweep_ff;
            sh_in   = pick_idx + 1'b1;
            if (pick_last) begin
               gpos_wide             = 32'(pick_pos);
               active_count_in       = count_last;
               rsp_valid_in          = 1'b1;
               rsp_in.status         = fsrs_pkg::ST_GRANTED;
               rsp_in.grant_id       = pick_id;
               rsp_in.grant_position = gpos_wide[15:0];
               rsp_in.moving_up      = pick_found ? sweep_ff : !sweep_ff;
            end
         end
         fsrs_pkg::S_SHIFT: begin
            rd_addr    = sh_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = sh_ff - 1'b1;
            sh_in      = sh_ff + 1'b1;
         end
         fsrs_pkg::S_FLUSH: begin
            active_count_in       = count_last;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = fsrs_pkg::ST_GRANTED;
            rsp_in.grant_id       = gid_ff;
            rsp_in.grant_position = gpos_wide[15:0];
            rsp_in.moving_up      = sweep_ff;
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= fsrs_pkg::S_IDLE;
         active_count_ff  <= '0;
         waiting_count_ff <= '0;
         sel_ff           <= 1'b0;
         sweep_ff         <= 1'b1;
         rd_v_ff          <= 1'b0;
         wr_pend_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         active_count_ff  <= active_count_in;
         waiting_count_ff <= waiting_count_in;
         sel_ff           <= sel_in;
         sweep_ff         <= sweep_in;
         rd_v_ff          <= rd_v_in;
         wr_pend_ff       <= wr_pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      head_ff    <= head_in;
      idx_ff     <= idx_in;
      rd_idx_ff  <= rd_idx_in;
      sh_ff      <= sh_in;
      wr_addr_ff <= wr_addr_in;
      gid_ff     <= gid_in;
      gpos_ff    <= gpos_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != fsrs_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // An accepted add is answered on the next cycle.
   a_add_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.action == fsrs_pkg::ACT_ADD) |=> rsp_valid)
      else $error("add beat not answered");

   // Grant fields are zero on every response that is not a grant.
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != fsrs_pkg::ST_GRANTED) |->
      (rsp.grant_id == '0 && rsp.grant_position == '0))
      else $error("grant fields set on a non-grant response");

   // Neither queue ever holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (active_count_ff <= CW'(QUEUE_DEPTH)) && (waiting_count_ff <= CW'(QUEUE_DEPTH)))
      else $error("queue count beyond depth");

   // A shift beat reads strictly inside the active queue.
   a_shift_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsrs_pkg::S_SHIFT) |-> (CW'(sh_ff) < active_count_ff))
      else $error("shift read outside the active queue");

endmodule

FILE: src/fsrs_ram.sv
// -----------------------------------------------------------------------------
// fsrs_ram
// Simple dual-port queue store: one write port, one read port with the read
// data registered.
// -----------------------------------------------------------------------------
module fsrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/fsrs_pick.sv
// -----------------------------------------------------------------------------
// fsrs_pick
// Selection unit: takes one queue entry a cycle in queue order and keeps the
// nearest entry in the sweep direction and the extreme entry in that direction.
// -----------------------------------------------------------------------------
module fsrs_pick #(
   parameter int QUEUE_DEPTH   = fsrs_pkg::QUEUE_DEPTH_DEF,
   parameter int POSITION_BITS = fsrs_pkg::POSITION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           clear,
   input  logic                           valid,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] index,
   input  logic [fsrs_pkg::ID_BITS-1:0]   entry_id,
   input  logic [POSITION_BITS-1:0]       entry_pos,
   input  logic [POSITION_BITS-1:0]       head,
   input  logic                           sweep_up,
   output logic                           found,
   output logic [$clog2(QUEUE_DEPTH)-1:0] pick_idx,
   output logic [fsrs_pkg::ID_BITS-1:0]   pick_id,
   output logic [POSITION_BITS-1:0]       pick_pos
);

   localparam int IW = $clog2(QUEUE_DEPTH);

   logic                         found_ff;
   logic [IW-1:0]                best_idx_ff, ext_idx_ff;
   logic [fsrs_pkg::ID_BITS-1:0] best_id_ff, ext_id_ff;
   logic [POSITION_BITS-1:0]     best_pos_ff, ext_pos_ff;
   logic                         first, take_best, take_ext;

   // Strict compares keep the oldest entry on equal positions.
   always_comb begin
      first = (index == '0);
      if (sweep_up) begin
         take_best = (entry_pos >= head) && (!found_ff || entry_pos < best_pos_ff);
         take_ext  = first || (entry_pos > ext_pos_ff);
      end else begin
         take_best = (entry_pos <= head) && (!found_ff || entry_pos > best_pos_ff);
         take_ext  = first || (entry_pos < ext_pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         found_ff <= 1'b0;
      end else if (valid && take_best) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (valid && take_best) begin
         best_idx_ff <= index;
         best_id_ff  <= entry_id;
         best_pos_ff <= entry_pos;
      end
      if (valid && take_ext) begin
         ext_idx_ff <= index;
         ext_id_ff  <= entry_id;
         ext_pos_ff <= entry_pos;
      end
   end

   // Without a candidate in the sweep direction the extreme entry wins.
   assign found    = found_ff;
   assign pick_idx = found_ff ? best_idx_ff : ext_idx_ff;
   assign pick_id  = found_ff ? best_id_ff  : ext_id_ff;
   assign pick_pos = found_ff ? best_pos_ff : ext_pos_ff;

endmodule
